### sv/rph_pkg.sv
// ----------------------------------------------------------------------------
// rph_pkg
// Shared types and constants for the ratio percent histogram.
// ----------------------------------------------------------------------------
package rph_pkg;

    localparam int unsigned NUM_BINS  = 102;
    localparam int unsigned PCT_SCALE = 100;
    localparam int unsigned OVF_BIN   = 101;

    localparam int unsigned CNT_W   = 16;                 // variant count, read depth
    localparam int unsigned BIN_W   = 7;
    localparam int unsigned HIST_W  = 32;
    localparam int unsigned QBITS   = 8;                  // quotient bits, top one = overflow
    localparam int unsigned NUM_W   = CNT_W + BIN_W;      // count * 100 fits here
    localparam int unsigned STEP_W  = 3;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 40;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_RD   = 5'b00100,
        S_UPD  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

### sv/ratio_percent_histogram.sv
// ----------------------------------------------------------------------------
// ratio_percent_histogram
// Percent-ratio histogram: bins count*100/depth into 102 saturating counters.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser = req_type (0 add sample, 1 read bin), tdata carries
//   variant_count, read_depth and query_bin. Master stream returns one beat
//   per request: the bin touched and its count after the update.
//   An add runs a restoring divider one quotient bit per cycle (8 steps), then
//   a read-modify-write of the counter memory, and its result goes to the
//   output register. A read skips the divider. One request is in flight at
//   a time: the slave side is ready only while the state machine is idle.
//   The next beat is accepted as soon as the previous result sits in the
//   output register, even while the receiver has not yet taken it.
//   A depth of zero or a ratio above 100 percent lands in bin 101; a query
//   above 101 reads bin 101. Counters stick at all ones.
//   Reset clears all counters at once through per-bin valid bits; no sweep.
//   A stalled receiver holds the output beat; a finished request waits in
//   its last state until the output register frees up.
// ----------------------------------------------------------------------------
module ratio_percent_histogram (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [rph_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [15:0] variant_count,
                                                              // [31:16] read_depth,
                                                              // [38:32] query_bin, [39] zero
    input  logic [0:0]                         s_axis_tuser,  // [0] req_type
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [rph_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // [6:0] bin_index,
                                                              // [38:7] bin_count, [39] zero
);

    localparam int unsigned NB  = rph_pkg::NUM_BINS;
    localparam int unsigned BW  = rph_pkg::BIN_W;
    localparam int unsigned HW  = rph_pkg::HIST_W;
    localparam int unsigned NW  = rph_pkg::NUM_W;
    localparam int unsigned CW  = rph_pkg::CNT_W;
    localparam int unsigned QW  = rph_pkg::QBITS;
    localparam int unsigned SW  = rph_pkg::STEP_W;

    rph_pkg::t_state r_state, n_state;

    logic          r_kind,  n_kind;
    logic [BW-1:0] r_bin,   n_bin;
    logic [NW-1:0] r_rem,   n_rem;
    logic [NW-1:0] r_dsh,   n_dsh;
    logic [QW-1:0] r_quo,   n_quo;
    logic [SW-1:0] r_step,  n_step;
    logic          r_dzero, n_dzero;
    logic [HW-1:0] r_res,   n_res;

    logic          r_out_valid, n_out_valid;
    logic [BW-1:0] r_out_bin,   n_out_bin;
    logic [HW-1:0] r_out_cnt,   n_out_cnt;

    logic [HW-1:0] r_mem [NB];
    logic [NB-1:0] r_valid;
    logic [HW-1:0] r_rdata;
    logic          r_rd_vld;

    logic          w_accept;
    logic [CW-1:0] w_cnt_in;
    logic [CW-1:0] w_depth_in;
    logic [BW-1:0] w_query_in;
    logic [BW-1:0] w_query_sat;
    logic          w_ge;
    logic [QW-1:0] w_quo_next;
    logic [HW-1:0] w_cur;
    logic [HW-1:0] w_inc;
    logic          w_out_free;

    assign w_cnt_in   = s_axis_tdata[15:0];
    assign w_depth_in = s_axis_tdata[31:16];
    assign w_query_in = s_axis_tdata[38:32];
    assign w_query_sat = (w_query_in > BW'(rph_pkg::OVF_BIN)) ? BW'(rph_pkg::OVF_BIN)
                                                              : w_query_in;

    assign s_axis_tready = (r_state == rph_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // one restoring step: divisor slides right a bit each cycle
    assign w_ge       = (r_rem >= r_dsh);
    assign w_quo_next = {r_quo[QW-2:0], w_ge};

    assign w_cur = r_rd_vld ? r_rdata : '0;
    assign w_inc = (&w_cur) ? w_cur : w_cur + HW'(1);

    assign w_out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_bin       = r_bin;
        n_rem       = r_rem;
        n_dsh       = r_dsh;
        n_quo       = r_quo;
        n_step      = r_step;
        n_dzero     = r_dzero;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_bin   = r_out_bin;
        n_out_cnt   = r_out_cnt;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            rph_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_kind  = s_axis_tuser[0];
                    n_rem   = NW'(w_cnt_in) * NW'(rph_pkg::PCT_SCALE);
                    n_dsh   = {w_depth_in, {(NW-CW){1'b0}}};
                    n_dzero = (w_depth_in == '0);
                    n_quo   = '0;
                    n_step  = SW'(QW - 1);
                    if (s_axis_tuser[0] == rph_pkg::REQ_READ) begin
                        n_bin   = w_query_sat;
                        n_state = rph_pkg::S_RD;
                    end else begin
                        n_state = rph_pkg::S_DIV;
                    end
                end
            end
            rph_pkg::S_DIV: begin
                if (w_ge) begin
                    n_rem = r_rem - r_dsh;
                end
                n_dsh  = r_dsh >> 1;
                n_quo  = w_quo_next;
                n_step = r_step - SW'(1);
                if (r_step == '0) begin
                    // quotient of 128 or more shows in the top bit
                    if (r_dzero || w_quo_next[QW-1]
                        || (w_quo_next[BW-1:0] > BW'(rph_pkg::PCT_SCALE))) begin
                        n_bin = BW'(rph_pkg::OVF_BIN);
                    end else begin
                        n_bin = w_quo_next[BW-1:0];
                    end
                    n_state = rph_pkg::S_RD;
                end
            end
            rph_pkg::S_RD: begin
                n_state = rph_pkg::S_UPD;
            end
            rph_pkg::S_UPD: begin
                n_res   = (r_kind == rph_pkg::REQ_ADD) ? w_inc : w_cur;
                n_state = rph_pkg::S_DONE;
            end
            rph_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_bin   = r_bin;
                    n_out_cnt   = r_res;
                    n_state     = rph_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rph_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rph_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_bin     <= n_bin;
        r_rem     <= n_rem;
        r_dsh     <= n_dsh;
        r_quo     <= n_quo;
        r_step    <= n_step;
        r_dzero   <= n_dzero;
        r_res     <= n_res;
        r_out_bin <= n_out_bin;
        r_out_cnt <= n_out_cnt;
    end

    // counter memory: registered read, single write port
    always_ff @(posedge i_clk) begin
        if (r_state == rph_pkg::S_RD) begin
            r_rdata <= r_mem[r_bin];
        end
        if (r_state == rph_pkg::S_UPD && r_kind == rph_pkg::REQ_ADD) begin
            r_mem[r_bin] <= w_inc;
        end
    end

    // a bin never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (r_state == rph_pkg::S_RD) begin
                r_rd_vld <= r_valid[r_bin];
            end
            if (r_state == rph_pkg::S_UPD && r_kind == rph_pkg::REQ_ADD) begin
                r_valid[r_bin] <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_cnt, r_out_bin};

`ifndef SYNTH
    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] <= 7'(rph_pkg::OVF_BIN)))
        else $error("output bin out of range");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rph_pkg::S_DIV && r_step == '0) |=> (r_state == rph_pkg::S_RD))
        else $error("divider did not finish after its last step");

    a_add_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rph_pkg::S_UPD && r_kind == rph_pkg::REQ_ADD)
        |=> r_valid[$past(r_bin)])
        else $error("added bin not marked valid");

    a_bin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rph_pkg::S_UPD || r_state == rph_pkg::S_DONE) |-> $stable(r_bin))
        else $error("bin changed during update");
`endif

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the percent-ratio histogram against a cycle-free model.
// Add beats are binned by count*100/depth, with zero depth and ratios above
// 100 percent going to bin 101. Read beats return one counter. Each accepted
// request updates a local histogram copy and queues the expected bin and
// count. A monitor compares every output beat with the oldest entry. Both
// stream sides idle at random, and one long receiver hold fills the block.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned MAX_PRINTS  = 20;

    typedef struct packed {
        logic [rph_pkg::BIN_W-1:0]  bin;
        logic [rph_pkg::HIST_W-1:0] count;
    } t_bin_result;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [rph_pkg::IN_TDATA_W-1:0]     s_axis_tdata;   // [15:0] variant_count,
                                                        // [31:16] read_depth,
                                                        // [38:32] query_bin, [39] zero
    logic [0:0]                         s_axis_tuser;   // [0] req_type
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [rph_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;   // [6:0] bin_index,
                                                        // [38:7] bin_count, [39] zero

    logic [rph_pkg::HIST_W-1:0] hist_model [rph_pkg::NUM_BINS];
    t_bin_result                pending_bins [$];

    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned add_count;
    int unsigned read_count;
    int unsigned overflow_adds;
    int unsigned results_seen;
    int unsigned rx_hold_cycles;
    bit          tx_idle_on;
    bit          rx_idle_on;

    ratio_percent_histogram uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [rph_pkg::BIN_W-1:0] percent_bin_of(
            input logic [rph_pkg::CNT_W-1:0] cnt,
            input logic [rph_pkg::CNT_W-1:0] depth);
        logic [31:0] quot;
        if (depth == '0) begin
            return rph_pkg::BIN_W'(rph_pkg::OVF_BIN);
        end
        quot = (32'(cnt) * rph_pkg::PCT_SCALE) / 32'(depth);
        if (quot > rph_pkg::PCT_SCALE) begin
            return rph_pkg::BIN_W'(rph_pkg::OVF_BIN);
        end
        return quot[rph_pkg::BIN_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_PRINTS) begin
            $display("MISMATCH %s: got %0d, expected %0d (beat %0d)",
                     what, got, want, results_seen);
        end
        error_count++;
    endtask

    // Offer one request beat; predict its result at the accepting edge.
    task automatic send_request(input logic kind, input logic [rph_pkg::CNT_W-1:0] cnt,
                                input logic [rph_pkg::CNT_W-1:0] depth,
                                input logic [rph_pkg::BIN_W-1:0] qbin);
        int unsigned               gap;
        logic [rph_pkg::BIN_W-1:0] bin;
        gap = tx_idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, qbin, depth, cnt};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);

        if (kind == rph_pkg::REQ_ADD) begin
            bin = percent_bin_of(cnt, depth);
            if (hist_model[bin] != '1) begin
                hist_model[bin] = hist_model[bin] + 1'b1;
            end
            add_count++;
            if (bin == rph_pkg::OVF_BIN) overflow_adds++;
        end else begin
            bin = (qbin > rph_pkg::OVF_BIN) ? rph_pkg::BIN_W'(rph_pkg::OVF_BIN) : qbin;
            read_count++;
        end
        pending_bins.push_back('{bin: bin, count: hist_model[bin]});
    endtask

    function automatic logic [rph_pkg::BIN_W-1:0] any_bin();
        return rph_pkg::BIN_W'($urandom_range(0, 127));
    endfunction

    // Boundary ratios and the overflow cases; unused fields carry noise.
    task automatic test_directed_adds();
        send_request(rph_pkg::REQ_ADD, 16'd0,     16'd1,     any_bin());  // 0 percent
        send_request(rph_pkg::REQ_ADD, 16'd1,     16'd1,     any_bin());  // exactly 100
        send_request(rph_pkg::REQ_ADD, 16'hFFFF,  16'hFFFF,  any_bin());
        send_request(rph_pkg::REQ_ADD, 16'hFFFF,  16'd1,     any_bin());  // far above 100
        send_request(rph_pkg::REQ_ADD, 16'd0,     16'd0,     any_bin());  // zero depth
        send_request(rph_pkg::REQ_ADD, 16'hFFFF,  16'd0,     any_bin());
        send_request(rph_pkg::REQ_ADD, 16'd101,   16'd100,   any_bin());  // just past 100
        send_request(rph_pkg::REQ_ADD, 16'd1,     16'hFFFF,  any_bin());
        send_request(rph_pkg::REQ_ADD, 16'd50,    16'd100,   any_bin());
        send_request(rph_pkg::REQ_ADD, 16'd32768, 16'hFFFF,  any_bin());
        send_request(rph_pkg::REQ_ADD, 16'd99,    16'd100,   any_bin());
        send_request(rph_pkg::REQ_ADD, 16'd1,     16'd3,     any_bin());
        send_request(rph_pkg::REQ_ADD, 16'd2,     16'd3,     any_bin());
        send_request(rph_pkg::REQ_ADD, 16'd1,     16'd1,     7'h7F);      // again into bin 100
    endtask

    // Reads leave the counters alone; queries past 101 land on 101.
    task automatic test_directed_reads();
        send_request(rph_pkg::REQ_READ, 16'hFFFF, 16'hFFFF, 7'd0);
        send_request(rph_pkg::REQ_READ, 16'd0,    16'd0,    7'd50);
        send_request(rph_pkg::REQ_READ, 16'hA5A5, 16'h5A5A, 7'd100);
        send_request(rph_pkg::REQ_READ, 16'd0,    16'd0,    7'd101);
        send_request(rph_pkg::REQ_READ, 16'd0,    16'd0,    7'd102);
        send_request(rph_pkg::REQ_READ, 16'hFFFF, 16'd0,    7'h7F);
        send_request(rph_pkg::REQ_READ, 16'd0,    16'd0,    7'd101);
        send_request(rph_pkg::REQ_READ, 16'd0,    16'd0,    7'd33);
    endtask

    task automatic test_random_mix(input int unsigned n_items);
        int unsigned               pick;
        logic [rph_pkg::CNT_W-1:0] cnt;
        logic [rph_pkg::CNT_W-1:0] depth;
        logic [31:0]               near;
        for (int unsigned k = 0; k < n_items; k++) begin
            // Change the idling style every 40 beats; first stretch runs flat out.
            if (k % 40 == 0) begin
                tx_idle_on = (k == 0) ? 1'b0 : 1'($urandom_range(0, 1));
                rx_idle_on = (k == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            end
            pick  = $urandom_range(0, 19);
            depth = rph_pkg::CNT_W'($urandom_range(1, 65535));
            cnt   = rph_pkg::CNT_W'($urandom_range(0, depth));
            case (pick)
                0: begin
                    depth = '0;
                    cnt   = rph_pkg::CNT_W'($urandom);
                end
                1, 2: begin
                    depth = rph_pkg::CNT_W'($urandom);
                    cnt   = rph_pkg::CNT_W'($urandom);
                end
                3, 4: begin
                    depth = rph_pkg::CNT_W'($urandom_range(1, 200));
                    cnt   = rph_pkg::CNT_W'($urandom_range(0, 2 * depth));
                end
                5, 6: begin
                    // Straddle the 100/101 boundary.
                    near = 32'(depth) + $urandom_range(0, depth / 100 + 1);
                    cnt  = (near > 32'hFFFF) ? 16'hFFFF : near[rph_pkg::CNT_W-1:0];
                end
                default: ;
            endcase
            if (pick >= 15) begin
                send_request(rph_pkg::REQ_READ, rph_pkg::CNT_W'($urandom),
                             rph_pkg::CNT_W'($urandom), any_bin());
            end else begin
                send_request(rph_pkg::REQ_ADD, cnt, depth, any_bin());
            end
        end
    endtask

    // Receiver stops for a long stretch while beats keep coming back to back.
    task automatic test_backpressure();
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        rx_hold_cycles = 250;
        for (int unsigned k = 0; k < 20; k++) begin
            send_request(k[0] ? rph_pkg::REQ_READ : rph_pkg::REQ_ADD,
                         rph_pkg::CNT_W'($urandom_range(0, 300)),
                         rph_pkg::CNT_W'($urandom_range(0, 300)), any_bin());
        end
    endtask

    // Full dump in bin order.
    task automatic test_readout_all();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int unsigned b = 0; b < rph_pkg::NUM_BINS; b++) begin
            send_request(rph_pkg::REQ_READ, rph_pkg::CNT_W'($urandom),
                         rph_pkg::CNT_W'($urandom), rph_pkg::BIN_W'(b));
        end
    endtask

    // Receiver: random stall per beat, plus an optional long hold.
    initial begin
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            int unsigned stall;
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                while (rx_hold_cycles > 0) begin
                    @(posedge i_clk);
                    rx_hold_cycles--;
                end
            end
            stall = rx_idle_on ? $urandom_range(0, 12) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_bin_result want;
            if (pending_bins.size() == 0) begin
                report_mismatch("unexpected beat, bin", 32'(m_axis_tdata[6:0]), 32'd0);
            end else begin
                want = pending_bins.pop_front();
                if (m_axis_tdata[6:0] != want.bin) begin
                    report_mismatch("bin_index", 32'(m_axis_tdata[6:0]), 32'(want.bin));
                end
                if (m_axis_tdata[38:7] != want.count) begin
                    report_mismatch("bin_count", m_axis_tdata[38:7], want.count);
                end
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_bins.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        error_count    = 0;
        cycle_count    = 0;
        add_count      = 0;
        read_count     = 0;
        overflow_adds  = 0;
        results_seen   = 0;
        rx_hold_cycles = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        for (int unsigned b = 0; b < rph_pkg::NUM_BINS; b++) hist_model[b] = '0;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_adds();
        test_directed_reads();
        test_random_mix(260);
        test_backpressure();
        test_readout_all();
        s_axis_tvalid <= 1'b0;

        wait (pending_bins.size() == 0);
        repeat (30) @(posedge i_clk);

        $display("Covered %0d adds (%0d into the overflow bin) and %0d reads,",
                 add_count, overflow_adds, read_count);
        $display("with a long output hold and a full in-order dump; %0d mismatches.",
                 error_count);
        if (error_count == 0 && pending_bins.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
sv/rph_pkg.sv
sv/ratio_percent_histogram.sv
bench/testbench.sv
